// File: rtl/core/discrete_cdf_sampler_top_defines.svh
// Assertion macros shared by the sampler modules.
`ifndef DISCRETE_CDF_SAMPLER_TOP_DEFINES_SVH
`define DISCRETE_CDF_SAMPLER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define DCS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sampler check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define DCS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sampler check failed");

`endif

// File: rtl/core/dcs_pkg.sv
// Types, codes and constants shared by the sampler modules.
`timescale 1ns / 1ps
package dcs_pkg;

    localparam int MAX_ENTRIES_DEF = 256;
    localparam int CUM_W           = 33;
    localparam int POS_W           = 16;
    localparam int DATA_W          = CUM_W + POS_W;
    localparam int SUM_W           = 34;

    localparam logic [SUM_W-1:0] ONE_SUM       = 34'h1_0000_0000;
    localparam logic [CUM_W-1:0] ONE_CUM       = 33'h1_0000_0000;
    localparam logic [SUM_W-1:0] SUM_TOLERANCE = 34'd43;

    typedef enum logic [1:0] {
        M_CLEAR  = 2'd0,
        M_APPEND = 2'd1,
        M_FINISH = 2'd2,
        M_DRAW   = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_OVER  = 3'd1,
        ST_UNDER = 3'd2,
        ST_FULL  = 3'd3,
        ST_NONE  = 3'd4,
        ST_DUP   = 3'd5
    } t_status;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_SEARCH = 1'b1
    } t_state;

    typedef struct packed {
        logic [CUM_W-1:0] last_cum;
        logic [POS_W-1:0] last_pos;
    } t_tbl_info;

    typedef struct packed {
        logic    valid;
        t_status status;
    } t_tbl_res;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] idx;
        t_status          status;
    } t_draw_res;

endpackage

// File: rtl/core/dcs_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
`timescale 1ns / 1ps
module dcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/dcs_table.sv
// Table builder: running sum, entry count, positions and the append and finish checks.
`timescale 1ns / 1ps
`include "discrete_cdf_sampler_top_defines.svh"
module dcs_table
    import dcs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_accept,
    input  t_mode                            i_mode,
    input  logic [CUM_W-1:0]                 i_weight,
    output logic [$clog2(MAX_ENTRIES+1)-1:0] o_count,
    output t_tbl_info                        o_info,
    output t_tbl_res                         o_res,
    output logic                             o_we,
    output logic [$clog2(MAX_ENTRIES)-1:0]   o_waddr,
    output logic [DATA_W-1:0]                o_wdata
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);

    logic [CW-1:0]    r_count, n_count;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [CUM_W-1:0] r_last_cum, n_last_cum;
    logic [POS_W-1:0] r_last_pos, n_last_pos;

    logic [SUM_W-1:0] w_sum;
    logic [CUM_W-1:0] w_clamped;
    logic             w_over;
    logic             w_dup;
    logic             w_full;

    assign w_sum     = r_sum + {1'b0, i_weight};
    assign w_over    = w_sum > (ONE_SUM + SUM_TOLERANCE);
    assign w_clamped = (w_sum > ONE_SUM) ? ONE_CUM : w_sum[CUM_W-1:0];
    assign w_dup     = (r_count != '0) && (r_last_cum == w_clamped);
    assign w_full    = r_count == CW'(MAX_ENTRIES);

    always_comb begin
        n_count    = r_count;
        n_sum      = r_sum;
        n_pos      = r_pos;
        n_last_cum = r_last_cum;
        n_last_pos = r_last_pos;
        o_we       = 1'b0;
        o_waddr    = r_count[AW-1:0];
        o_wdata    = {w_clamped, r_pos};
        o_res      = '{valid: 1'b0, status: ST_OK};
        if (i_accept) begin
            unique case (i_mode)
                M_CLEAR: begin
                    o_res.valid = 1'b1;
                    n_count     = '0;
                    n_sum       = '0;
                    n_pos       = '0;
                end
                M_APPEND: begin
                    o_res.valid = 1'b1;
                    n_pos       = r_pos + 1'b1;
                    if (i_weight == '0) begin
                        o_res.status = ST_OK;
                    end else if (w_over) begin
                        o_res.status = ST_OVER;
                    end else if (w_dup) begin
                        o_res.status = ST_DUP;
                        n_sum        = {1'b0, w_clamped};
                    end else if (w_full) begin
                        o_res.status = ST_FULL;
                    end else begin
                        o_we       = 1'b1;
                        n_sum      = {1'b0, w_clamped};
                        n_count    = r_count + 1'b1;
                        n_last_cum = w_clamped;
                        n_last_pos = r_pos;
                    end
                end
                M_FINISH: begin
                    o_res.valid = 1'b1;
                    if ((r_sum < ONE_SUM) && ((ONE_SUM - r_sum) > SUM_TOLERANCE)) begin
                        o_res.status = ST_UNDER;
                    end
                end
                M_DRAW: begin
                    o_res.valid = 1'b0;
                end
                default: begin
                    o_res.valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sum   <= '0;
            r_pos   <= '0;
        end else begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_pos   <= n_pos;
        end
        r_last_cum <= n_last_cum;
        r_last_pos <= n_last_pos;
    end

    assign o_count = r_count;
    assign o_info  = '{last_cum: r_last_cum, last_pos: r_last_pos};

    `DCS_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_ENTRIES))
    `DCS_ASSERT_SAME(a_sum_bound, i_clk, i_rst_n, 1'b1, r_sum <= ONE_SUM)

endmodule

// File: rtl/core/dcs_search.sv
// Draw sequencer: binary search over the cumulative table, one memory read per step.
`timescale 1ns / 1ps
`include "discrete_cdf_sampler_top_defines.svh"
module dcs_search
    import dcs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start_draw,
    input  logic [CUM_W-1:0]                 i_uniform,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0] i_count,
    input  t_tbl_info                        i_info,
    input  logic [DATA_W-1:0]                i_rdata,
    output logic                             o_re,
    output logic [$clog2(MAX_ENTRIES)-1:0]   o_raddr,
    output logic                             o_busy,
    output t_draw_res                        o_res
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);

    t_state r_state, n_state;

    logic [CW-1:0]    r_lo, n_lo;
    logic [CW-1:0]    r_hi, n_hi;
    logic [CW-1:0]    r_mid, n_mid;
    logic [31:0]      r_u, n_u;
    logic             r_found, n_found;
    logic [POS_W-1:0] r_cand, n_cand;

    logic [CUM_W-1:0] w_u_sat;
    logic             w_launch;
    logic [CUM_W-1:0] w_cum;
    logic [POS_W-1:0] w_pos;
    logic             w_gt;
    logic [CW-1:0]    w_lo_step;
    logic [CW-1:0]    w_hi_step;
    logic [CW-1:0]    w_mid_step;
    logic             w_found_step;
    logic [POS_W-1:0] w_cand_step;
    logic             w_more;

    assign w_u_sat  = (i_uniform > ONE_CUM) ? ONE_CUM : i_uniform;
    assign w_launch = i_start_draw && (w_u_sat != '0) && (w_u_sat != ONE_CUM) &&
                      (i_count != '0);

    assign w_cum        = i_rdata[DATA_W-1:POS_W];
    assign w_pos        = i_rdata[POS_W-1:0];
    assign w_gt         = w_cum > {1'b0, r_u};
    assign w_lo_step    = w_gt ? r_lo : CW'(r_mid + 1'b1);
    assign w_hi_step    = w_gt ? r_mid : r_hi;
    assign w_found_step = w_gt | r_found;
    assign w_cand_step  = w_gt ? w_pos : r_cand;
    assign w_mid_step   = CW'(({1'b0, w_lo_step} + {1'b0, w_hi_step}) >> 1);
    assign w_more       = w_lo_step < w_hi_step;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_launch) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (!w_more) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_mid   = r_mid;
        n_u     = r_u;
        n_found = r_found;
        n_cand  = r_cand;
        o_re    = 1'b0;
        o_raddr = r_mid[AW-1:0];
        o_res   = '{valid: 1'b0, idx: '0, status: ST_OK};
        unique case (r_state)
            S_IDLE: begin
                if (i_start_draw) begin
                    if (w_u_sat == '0) begin
                        o_res.valid = 1'b1;
                    end else if (w_u_sat == ONE_CUM) begin
                        o_res.valid = 1'b1;
                        if ((i_count != '0) && (i_info.last_cum == ONE_CUM)) begin
                            o_res.idx = i_info.last_pos;
                        end else begin
                            o_res.status = ST_NONE;
                        end
                    end else if (i_count == '0) begin
                        o_res.valid  = 1'b1;
                        o_res.status = ST_NONE;
                    end else begin
                        n_lo    = '0;
                        n_hi    = i_count;
                        n_mid   = i_count >> 1;
                        n_u     = w_u_sat[31:0];
                        n_found = 1'b0;
                        n_cand  = '0;
                        o_re    = 1'b1;
                        o_raddr = n_mid[AW-1:0];
                    end
                end
            end
            S_SEARCH: begin
                n_lo    = w_lo_step;
                n_hi    = w_hi_step;
                n_found = w_found_step;
                n_cand  = w_cand_step;
                if (w_more) begin
                    n_mid   = w_mid_step;
                    o_re    = 1'b1;
                    o_raddr = w_mid_step[AW-1:0];
                end else begin
                    o_res.valid = 1'b1;
                    if (w_found_step) begin
                        o_res.idx = w_cand_step;
                    end else begin
                        o_res.status = ST_NONE;
                    end
                end
            end
            default: begin
                o_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
        r_u     <= n_u;
        r_found <= n_found;
        r_cand  <= n_cand;
    end

    assign o_busy = r_state == S_SEARCH;

    `DCS_ASSERT_SAME(a_window_open, i_clk, i_rst_n, r_state == S_SEARCH,
        (r_lo <= r_mid) && (r_mid < r_hi))
    `DCS_ASSERT_SAME(a_window_in_table, i_clk, i_rst_n, r_state == S_SEARCH,
        r_hi <= i_count)
    `DCS_ASSERT_SAME(a_no_draw_while_busy, i_clk, i_rst_n, i_start_draw,
        r_state == S_IDLE)
    `DCS_ASSERT_NEXT(a_done_frees, i_clk, i_rst_n, o_res.valid && (r_state == S_SEARCH),
        r_state == S_IDLE)

endmodule

// File: rtl/core/discrete_cdf_sampler_top.sv
// Top level of the discrete inverse-CDF sampler.
//
// A request is taken at a rising clock edge where start is high and busy is low.
// i_mode selects clear, append weight, finish check or draw sample; i_weight is used
// by append and i_uniform by draw. Every request gives exactly one result, shown on
// o_chosen_index and o_status for one cycle while o_valid is high; the receiver
// cannot hold results off, so it must take each result in that cycle.
// Clear, append and finish results appear one cycle after the request, and busy
// stays low, so such requests may follow each other in every cycle.
// A draw with a uniform value of zero or one, or on an empty table, also answers in
// the cycle after the request. Any other draw runs a binary search over the cumulative
// table, one registered read of the table memory per step, followed by the output
// register; busy is high during the search.
// Reset clears the entry count, the running sum, the position counter and the
// sequencer; the table memory is not cleared, since only entries below the count
// are ever read.
`timescale 1ns / 1ps
module discrete_cdf_sampler_top
    import dcs_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_mode,
    input  logic [CUM_W-1:0]    i_weight,
    input  logic [CUM_W-1:0]    i_uniform,
    output logic                o_valid,
    output logic [POS_W-1:0]    o_chosen_index,
    output logic [2:0]          o_status
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = $clog2(MAX_ENTRIES);

    logic              w_accept;
    t_mode             w_mode;
    logic [CW-1:0]     w_count;
    t_tbl_info         w_info;
    t_tbl_res          w_tbl_res;
    t_draw_res         w_draw_res;
    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [DATA_W-1:0] w_wdata;
    logic              w_re;
    logic [AW-1:0]     w_raddr;
    logic [DATA_W-1:0] w_rdata;
    logic              w_busy;

    logic              r_valid, n_valid;
    logic [POS_W-1:0]  r_idx, n_idx;
    t_status           r_status, n_status;

    assign w_mode   = t_mode'(i_mode);
    assign w_accept = start && !w_busy;

    dcs_table #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_mode   (w_mode),
        .i_weight (i_weight),
        .o_count  (w_count),
        .o_info   (w_info),
        .o_res    (w_tbl_res),
        .o_we     (w_we),
        .o_waddr  (w_waddr),
        .o_wdata  (w_wdata)
    );

    dcs_ram #(
        .WIDTH(DATA_W),
        .DEPTH(MAX_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    dcs_search #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_search (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start_draw (w_accept && (w_mode == M_DRAW)),
        .i_uniform    (i_uniform),
        .i_count      (w_count),
        .i_info       (w_info),
        .i_rdata      (w_rdata),
        .o_re         (w_re),
        .o_raddr      (w_raddr),
        .o_busy       (w_busy),
        .o_res        (w_draw_res)
    );

    always_comb begin
        n_valid  = w_tbl_res.valid || w_draw_res.valid;
        n_idx    = '0;
        n_status = w_tbl_res.status;
        if (w_draw_res.valid) begin
            n_idx    = w_draw_res.idx;
            n_status = w_draw_res.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_idx    <= n_idx;
        r_status <= n_status;
    end

    assign busy           = w_busy;
    assign o_valid        = r_valid;
    assign o_chosen_index = r_idx;
    assign o_status       = r_status;

endmodule
